// ===== rtl/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types and constants for the SHA-256 message hasher: beat formats of
// the request, result and internal word queue, opcodes, round constants and
// initial hash values.
// ----------------------------------------------------------------------------
package sha_pkg;

   // request opcodes
   localparam logic OP_ABSORB = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   // request beat
   typedef struct packed {
      logic       opcode;
      logic [7:0] data_byte;
   } req_type;

   // result beat
   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // message word passed from front to back, last marks the final padded word
   typedef struct packed {
      logic        last;
      logic [31:0] word;
   } word_beat_type;

   localparam int WORDS_PER_BLOCK = 16;
   localparam int ROUNDS          = 64;
   localparam int HASH_WORDS      = 8;

   // padding constants
   localparam logic [7:0] PAD_BYTE       = 8'h80;
   localparam logic [3:0] LEN_WORD_HIGH  = 4'd14;
   localparam logic [3:0] LEN_WORD_LOW   = 4'd15;

   localparam logic [31:0] INITIAL_H [HASH_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage

// ===== rtl/sha256_message_hasher.sv =====
// ----------------------------------------------------------------------------
// sha256_message_hasher
// SHA-256 over a byte stream: a padding front feeds 32-bit words through a
// short queue to a one-round-per-cycle compression back end.
// ----------------------------------------------------------------------------
// back end: a block runs 64 rounds (held in rounds 0 to 15 on an empty queue)
//    and one add; the digest comes out after the last block as 8 beats, one
//    per cycle while popped; the front takes one byte per cycle unless full,
//    waiting on the full queue during rounds 16 to 63; finish holds input off
//    for 2 to 17 padding words, longer on a full queue
// reset: synchronous, loads the initial hash values, no clearing pass
// ----------------------------------------------------------------------------
module sha256_message_hasher #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  sha_pkg::req_type req_item,
   output logic             empty,
   input  logic             pop,
   output sha_pkg::rsp_type rsp_item
);
   import sha_pkg::*;

   word_beat_type front_beat, back_beat;
   logic          front_push, queue_full;
   logic          back_pop, queue_empty;

   // padding front
   sha_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .wq_push  (front_push),
      .wq_beat  (front_beat),
      .wq_full  (queue_full)
   );

   // word queue
   sha_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_push  (front_push),
      .wr_beat  (front_beat),
      .wr_full  (queue_full),
      .rd_pop   (back_pop),
      .rd_beat  (back_beat),
      .rd_empty (queue_empty)
   );

   // compression back end
   sha_core u_core (
      .clock    (clock),
      .reset    (reset),
      .wq_pop   (back_pop),
      .wq_beat  (back_beat),
      .wq_empty (queue_empty),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

endmodule

// ===== rtl/sha_fifo.sv =====
// ----------------------------------------------------------------------------
// sha_fifo
// Small word queue between the padding front and the compression back.
// DEPTH must be 2 or more.
// ----------------------------------------------------------------------------
module sha_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_push,
   input  sha_pkg::word_beat_type wr_beat,
   output logic                   wr_full,
   input  logic                   rd_pop,
   output sha_pkg::word_beat_type rd_beat,
   output logic                   rd_empty
);
   import sha_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   word_beat_type      mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign wr_full  = (count_ff == CNT_W'(DEPTH));
   assign rd_empty = (count_ff == '0);
   assign do_push  = wr_push && !wr_full;
   assign do_pop   = rd_pop && !rd_empty;
   assign rd_beat  = mem_ff[rd_ptr_ff];

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_beat;
      end
   end

endmodule

// ===== rtl/sha_front.sv =====
// ----------------------------------------------------------------------------
// sha_front
// Takes request beats, packs message bytes into big-endian words, counts
// message bits and, on finish, emits the 0x80 marker, zero fill and the
// 64-bit length as padding words.
// ----------------------------------------------------------------------------
module sha_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  sha_pkg::req_type       req_item,
   output logic                   wq_push,
   output sha_pkg::word_beat_type wq_beat,
   input  logic                   wq_full
);
   import sha_pkg::*;

   localparam logic ST_BYTES = 1'b0;
   localparam logic ST_PAD   = 1'b1;

   logic        state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic [31:0] word_ff, word_in;
   logic [3:0]  wc_ff, wc_in;
   logic        wrap_ff, wrap_in;
   logic        accept;
   logic [1:0]  lane_pos;
   logic [3:0]  word_pos;
   logic [31:0] absorb_word, marker_word;
   logic        pad_len;

   assign full     = (state_ff == ST_PAD) || wq_full;
   assign accept   = push && !full;
   assign lane_pos = fill_ff[1:0];
   assign word_pos = fill_ff[5:2];
   assign pad_len  = (wc_ff >= LEN_WORD_HIGH) && !wrap_ff;

   // byte lane merge, lane 0 is the most significant byte
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         if (2'(l) < lane_pos) begin
            absorb_word[31-8*l -: 8] = word_ff[31-8*l -: 8];
            marker_word[31-8*l -: 8] = word_ff[31-8*l -: 8];
         end else if (2'(l) == lane_pos) begin
            absorb_word[31-8*l -: 8] = req_item.data_byte;
            marker_word[31-8*l -: 8] = PAD_BYTE;
         end else begin
            absorb_word[31-8*l -: 8] = 8'h00;
            marker_word[31-8*l -: 8] = 8'h00;
         end
      end
   end

   // next state and queue writes
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      bits_in      = bits_ff;
      word_in      = word_ff;
      wc_in        = wc_ff;
      wrap_in      = wrap_ff;
      wq_push      = 1'b0;
      wq_beat.last = 1'b0;
      wq_beat.word = absorb_word;
      unique case (state_ff)
         ST_BYTES: begin
            if (accept) begin
               if (req_item.opcode == OP_ABSORB) begin
                  word_in = absorb_word;
                  fill_in = fill_ff + 1'b1;
                  bits_in = bits_ff + 64'd8;
                  wq_push = (lane_pos == 2'd3);
               end else begin
                  // marker word, then fill words follow in pad state
                  wq_push      = 1'b1;
                  wq_beat.word = marker_word;
                  wc_in        = word_pos + 1'b1;
                  wrap_in      = (word_pos == LEN_WORD_HIGH);
                  state_in     = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            wq_beat.word = 32'h0;
            if (pad_len) begin
               wq_beat.word = wc_ff[0] ? bits_ff[31:0] : bits_ff[63:32];
            end
            wq_beat.last = pad_len && (wc_ff == LEN_WORD_LOW);
            if (!wq_full) begin
               wq_push = 1'b1;
               wc_in   = wc_ff + 1'b1;
               if (wc_ff == LEN_WORD_LOW) begin
                  wrap_in = 1'b0;
               end
               if (wq_beat.last) begin
                  state_in = ST_BYTES;
                  fill_in  = '0;
                  bits_in  = '0;
               end
            end
         end
         default: state_in = ST_BYTES;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_BYTES;
         fill_ff  <= '0;
         bits_ff  <= '0;
         wc_ff    <= '0;
         wrap_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
         wc_ff    <= wc_in;
         wrap_ff  <= wrap_in;
      end
   end

   // partial word holds no control state
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

endmodule

// ===== rtl/sha_core.sv =====
// ----------------------------------------------------------------------------
// sha_core
// Compression back end: one round per cycle, held on an empty queue in rounds
// 0-15; 16-word message schedule window, feed-forward add, digest read-out.
// ----------------------------------------------------------------------------
module sha_core (
   input  logic                   clock,
   input  logic                   reset,
   output logic                   wq_pop,
   input  sha_pkg::word_beat_type wq_beat,
   input  logic                   wq_empty,
   output logic                   empty,
   input  logic                   pop,
   output sha_pkg::rsp_type       rsp_item
);
   import sha_pkg::*;

   localparam logic [1:0] ST_ROUND = 2'd0;
   localparam logic [1:0] ST_SUM   = 2'd1;
   localparam logic [1:0] ST_EMIT  = 2'd2;

   function automatic logic [31:0] big0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

   logic [1:0]  state_ff, state_in;
   logic [5:0]  round_ff, round_in;
   logic [2:0]  idx_ff, idx_in;
   logic        final_ff, final_in;
   logic [31:0] h_ff [HASH_WORDS];
   logic [31:0] v_ff [HASH_WORDS];
   logic [31:0] win_ff [WORDS_PER_BLOCK];
   logic [31:0] sched_ff, sched_in;
   logic [31:0] w_cur;
   logic [31:0] t1, t2, ch, maj;
   logic        load_phase, step;
   logic        do_emit;

   assign load_phase = (round_ff < 6'(WORDS_PER_BLOCK));
   assign step       = (state_ff == ST_ROUND) && (!load_phase || !wq_empty);
   assign wq_pop     = (state_ff == ST_ROUND) && load_phase && !wq_empty;

   // message schedule for rounds 16 to 63, worked out one round ahead
   assign sched_in = small1(win_ff[15]) + win_ff[10] + small0(win_ff[2]) + win_ff[1];
   assign w_cur    = load_phase ? wq_beat.word : sched_ff;

   // round function
   assign ch  = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign t1  = v_ff[7] + big1(v_ff[4]) + ch + ROUND_K[round_ff] + w_cur;
   assign t2  = big0(v_ff[0]) + maj;

   // digest read-out
   assign empty               = (state_ff != ST_EMIT);
   assign do_emit             = pop && !empty;
   assign rsp_item.digest_word = h_ff[idx_ff];
   assign rsp_item.word_index  = idx_ff;
   assign rsp_item.last_word   = (idx_ff == 3'd7);

   // sequencer
   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      idx_in   = idx_ff;
      final_in = final_ff;
      unique case (state_ff)
         ST_ROUND: begin
            if (step) begin
               round_in = round_ff + 1'b1;
               if (wq_pop && wq_beat.last) begin
                  final_in = 1'b1;
               end
               if (round_ff == 6'(ROUNDS - 1)) begin
                  state_in = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            idx_in   = '0;
            state_in = final_ff ? ST_EMIT : ST_ROUND;
         end
         ST_EMIT: begin
            if (do_emit) begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff == 3'd7) begin
                  final_in = 1'b0;
                  state_in = ST_ROUND;
               end
            end
         end
         default: state_in = ST_ROUND;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ROUND;
         round_ff <= '0;
         idx_ff   <= '0;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
         final_ff <= final_in;
      end
   end

   // working variables and chaining value
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HASH_WORDS; i++) begin
            h_ff[i] <= INITIAL_H[i];
            v_ff[i] <= INITIAL_H[i];
         end
      end else if (step) begin
         v_ff[0] <= t1 + t2;
         v_ff[1] <= v_ff[0];
         v_ff[2] <= v_ff[1];
         v_ff[3] <= v_ff[2];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[5] <= v_ff[4];
         v_ff[6] <= v_ff[5];
         v_ff[7] <= v_ff[6];
      end else if (state_ff == ST_SUM) begin
         for (int i = 0; i < HASH_WORDS; i++) begin
            h_ff[i] <= h_ff[i] + v_ff[i];
            v_ff[i] <= h_ff[i] + v_ff[i];
         end
      end else if (do_emit && (idx_ff == 3'd7)) begin
         for (int i = 0; i < HASH_WORDS; i++) begin
            h_ff[i] <= INITIAL_H[i];
            v_ff[i] <= INITIAL_H[i];
         end
      end
   end

   // schedule window, oldest word at the bottom
   always_ff @(posedge clock) begin
      if (step) begin
         for (int i = 0; i < WORDS_PER_BLOCK - 1; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
         win_ff[WORDS_PER_BLOCK-1] <= w_cur;
         sched_ff                  <= sched_in;
      end
   end

endmodule
